// ===== design/nested_region_latency_stats_core_assert.svh =====
// Assertion macros for the region profiler.
`ifndef NESTED_REGION_LATENCY_STATS_CORE_ASSERT_SVH
`define NESTED_REGION_LATENCY_STATS_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define NRLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nrls: same-cycle check failed");

`define NRLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nrls: next-cycle check failed");

`else

`define NRLS_ASSERT_NOW(label, clk, rst, ante, cons)

`define NRLS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/nrls_pkg.sv =====
`default_nettype none

package nrls_pkg;

   localparam int OP_W           = 2;
   localparam int CAT_W          = 5;
   localparam int TS_W           = 64;
   localparam int CNT_W          = 32;
   localparam int STATUS_W       = 2;
   localparam int CATEGORY_COUNT = 32;
   localparam int STACK_DEPTH    = 8;
   localparam int SP_W           = $clog2(STACK_DEPTH + 1);
   localparam int STK_IDX_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
   localparam logic [OP_W-1:0] OP_LEAVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [TS_W-1:0]  lat_total;
      logic [TS_W-1:0]  occ_total;
      logic [TS_W-1:0]  lat_min;
      logic [TS_W-1:0]  lat_max;
      logic [TS_W-1:0]  occ_min;
      logic [TS_W-1:0]  occ_max;
   } stats_type;

   typedef struct packed {
      logic             active;
      logic [CAT_W-1:0] cat;
      logic [TS_W-1:0]  lat_start;
      logic [TS_W-1:0]  occ_start;
      logic [TS_W-1:0]  accum;
   } ctx_type;

   typedef struct packed {
      logic             en;
      logic [CAT_W-1:0] addr;
      stats_type        data;
   } stats_wr_type;

   typedef struct packed {
      logic                 en;
      logic [STK_IDX_W-1:0] addr;
      ctx_type              data;
   } stack_wr_type;

endpackage

`default_nettype wire

// ===== design/nrls_req_if.sv =====
`default_nettype none

interface nrls_req_if;
   logic                        valid;
   logic                        ready;
   logic [nrls_pkg::OP_W-1:0]   operation;
   logic [nrls_pkg::CAT_W-1:0]  category;
   logic [nrls_pkg::TS_W-1:0]   timestamp;
   logic                        nest;

   modport source (output valid, output operation, output category, output timestamp,
                   output nest, input ready);
   modport sink (input valid, input operation, input category, input timestamp,
                 input nest, output ready);
endinterface

`default_nettype wire

// ===== design/nrls_rsp_if.sv =====
`default_nettype none

interface nrls_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [nrls_pkg::STATUS_W-1:0] status;
   logic [nrls_pkg::CNT_W-1:0]    region_count;
   logic [nrls_pkg::TS_W-1:0]     total_latency;
   logic [nrls_pkg::TS_W-1:0]     total_occupancy;
   logic [nrls_pkg::TS_W-1:0]     min_latency;
   logic [nrls_pkg::TS_W-1:0]     max_latency;
   logic [nrls_pkg::TS_W-1:0]     min_occupancy;
   logic [nrls_pkg::TS_W-1:0]     max_occupancy;

   modport source (output valid, output status, output region_count, output total_latency,
                   output total_occupancy, output min_latency, output max_latency,
                   output min_occupancy, output max_occupancy, input ready);
   modport sink (input valid, input status, input region_count, input total_latency,
                 input total_occupancy, input min_latency, input max_latency,
                 input min_occupancy, input max_occupancy, output ready);
endinterface

`default_nettype wire

// ===== design/nrls_stats_ram.sv =====
`default_nettype none

module nrls_stats_ram (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [nrls_pkg::CAT_W-1:0]  rd_addr,
   output nrls_pkg::stats_type         rd_data,
   input  nrls_pkg::stats_wr_type      wr
);
   import nrls_pkg::*;

   stats_type                 stats_mem_ff [CATEGORY_COUNT];
   logic [CATEGORY_COUNT-1:0] valid_ff;
   stats_type                 rd_data_ff;
   logic                      rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         stats_mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff  <= stats_mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ===== design/nrls_stack_ram.sv =====
`default_nettype none

module nrls_stack_ram (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [nrls_pkg::STK_IDX_W-1:0] rd_addr,
   output nrls_pkg::ctx_type              rd_data,
   input  nrls_pkg::stack_wr_type         wr
);
   import nrls_pkg::*;

   ctx_type ctx_mem_ff [STACK_DEPTH];
   ctx_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ctx_mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= ctx_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/nrls_stats_update.sv =====
`default_nettype none

module nrls_stats_update (
   input  nrls_pkg::stats_type           old_stats,
   input  logic [nrls_pkg::TS_W-1:0]     lat,
   input  logic [nrls_pkg::TS_W-1:0]     occ,
   output nrls_pkg::stats_type           new_stats
);
   import nrls_pkg::*;

   always_comb begin
      new_stats.lat_total = old_stats.lat_total + lat;
      new_stats.occ_total = old_stats.occ_total + occ;
      if (old_stats.count == '0) begin
         new_stats.lat_min = lat;
         new_stats.lat_max = lat;
         new_stats.occ_min = occ;
         new_stats.occ_max = occ;
      end else begin
         new_stats.lat_min = (lat < old_stats.lat_min) ? lat : old_stats.lat_min;
         new_stats.lat_max = (lat > old_stats.lat_max) ? lat : old_stats.lat_max;
         new_stats.occ_min = (occ < old_stats.occ_min) ? occ : old_stats.occ_min;
         new_stats.occ_max = (occ > old_stats.occ_max) ? occ : old_stats.occ_max;
      end
      // saturating count
      new_stats.count = (old_stats.count == '1) ? old_stats.count
                                                : old_stats.count + CNT_W'(1);
   end

endmodule

`default_nettype wire

// ===== design/nested_region_latency_stats_core.sv =====
// Region latency/occupancy profiler.
// req_chan takes one word per event: enter (start a region in a category,
// optionally pushing the running context), leave (record latency and
// exclusive time into the running category, optionally popping the outer
// context) and read (return one category's statistics and clear them).
// rsp_chan returns one word for each read and for each stack overflow or
// underflow; other events return nothing.
// Each event is accepted in ST_IDLE, where the statistics and stack memories
// are read, then passes ST_CALC for the occupancy add and ST_COMMIT for the
// compare/accumulate and write-back. A returned word is registered at commit;
// no new event is taken until the last one has committed. Both memories are
// read once and written at most once per event, so no two accesses overlap.
// The result register frees req_chan while a word waits; an event that
// needs to return a word holds in ST_COMMIT until the waiting one drains.
// Synchronous reset empties the stack, ends any running region and marks
// every category as zero.
`default_nettype none

`include "nested_region_latency_stats_core_assert.svh"

module nested_region_latency_stats_core (
   input  logic        clock,
   input  logic        reset,
   nrls_req_if.sink    req_chan,
   nrls_rsp_if.source  rsp_chan
);
   import nrls_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CALC   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [OP_W-1:0]     op_ff;
   logic [CAT_W-1:0]    cat_ff;
   logic [TS_W-1:0]     now_ff;
   logic                nest_ff;
   logic [TS_W-1:0]     d_lat_ff, d_occ_ff, occ_ff;

   logic                active_ff, active_in;
   logic [CAT_W-1:0]    cur_cat_ff, cur_cat_in;
   logic [TS_W-1:0]     lat_start_ff, lat_start_in;
   logic [TS_W-1:0]     occ_start_ff, occ_start_in;
   logic [TS_W-1:0]     accum_ff, accum_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   logic [SP_W-1:0]     sp_dec;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   stats_type           rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                stack_full, stack_empty;
   logic                produce, can_go;
   logic [STATUS_W-1:0] status_val;
   stats_type           stats_rd, stats_upd;
   stats_wr_type        stats_wr;
   ctx_type             stack_rd;
   stack_wr_type        stack_wr;

   assign req_fire    = req_chan.valid && req_chan.ready;
   assign stack_full  = (sp_ff == SP_W'(STACK_DEPTH));
   assign stack_empty = (sp_ff == '0);
   assign sp_dec      = sp_ff - SP_W'(1);

   nrls_stats_ram u_stats_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr ((req_chan.operation == OP_READ) ? req_chan.category : cur_cat_ff),
      .rd_data (stats_rd),
      .wr      (stats_wr)
   );

   nrls_stack_ram u_stack_ram (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (sp_dec[STK_IDX_W-1:0]),
      .rd_data (stack_rd),
      .wr      (stack_wr)
   );

   nrls_stats_update u_stats_update (
      .old_stats (stats_rd),
      .lat       (d_lat_ff),
      .occ       (occ_ff),
      .new_stats (stats_upd)
   );

   always_comb begin
      produce = 1'b0;
      status_val = STATUS_OK;
      unique case (op_ff)
         OP_ENTER: begin
            produce    = nest_ff && stack_full;
            status_val = STATUS_OVERFLOW;
         end
         OP_LEAVE: begin
            produce    = nest_ff && stack_empty;
            status_val = STATUS_UNDERFLOW;
         end
         OP_READ: begin
            produce    = 1'b1;
            status_val = STATUS_OK;
         end
         default: begin
            produce    = 1'b0;
            status_val = STATUS_OK;
         end
      endcase
   end

   assign can_go = !produce || !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      cur_cat_in    = cur_cat_ff;
      lat_start_in  = lat_start_ff;
      occ_start_in  = occ_start_ff;
      accum_in      = accum_ff;
      sp_in         = sp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      stats_wr      = '0;
      stack_wr      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (can_go) begin
               state_in = ST_IDLE;
               if (produce) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = status_val;
                  rsp_data_in   = (op_ff == OP_READ) ? stats_rd : '0;
               end
               unique case (op_ff)
                  OP_ENTER: begin
                     if (nest_ff && !stack_full) begin
                        stack_wr.en   = 1'b1;
                        stack_wr.addr = sp_ff[STK_IDX_W-1:0];
                        if (active_ff) begin
                           stack_wr.data = '{active: 1'b1, cat: cur_cat_ff,
                                             lat_start: lat_start_ff,
                                             occ_start: occ_start_ff, accum: occ_ff};
                        end
                        sp_in = sp_ff + SP_W'(1);
                     end
                     active_in    = 1'b1;
                     cur_cat_in   = cat_ff;
                     lat_start_in = now_ff;
                     occ_start_in = now_ff;
                     accum_in     = '0;
                  end
                  OP_LEAVE: begin
                     if (active_ff) begin
                        stats_wr.en   = 1'b1;
                        stats_wr.addr = cur_cat_ff;
                        stats_wr.data = stats_upd;
                     end
                     if (nest_ff && !stack_empty) begin
                        sp_in        = sp_dec;
                        active_in    = stack_rd.active;
                        cur_cat_in   = stack_rd.cat;
                        lat_start_in = stack_rd.lat_start;
                        accum_in     = stack_rd.accum;
                        occ_start_in = now_ff;
                     end
                  end
                  OP_READ: begin
                     stats_wr.en   = 1'b1;
                     stats_wr.addr = cat_ff;
                     stats_wr.data = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         cur_cat_ff   <= '0;
         lat_start_ff <= '0;
         occ_start_ff <= '0;
         accum_ff     <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         cur_cat_ff   <= cur_cat_in;
         lat_start_ff <= lat_start_in;
         occ_start_ff <= occ_start_in;
         accum_ff     <= accum_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_chan.operation;
         cat_ff   <= req_chan.category;
         now_ff   <= req_chan.timestamp;
         nest_ff  <= req_chan.nest;
         d_lat_ff <= req_chan.timestamp - lat_start_ff;
         d_occ_ff <= req_chan.timestamp - occ_start_ff;
      end
      if (state_ff == ST_CALC) begin
         occ_ff <= d_occ_ff + accum_ff;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.region_count    = rsp_data_ff.count;
   assign rsp_chan.total_latency   = rsp_data_ff.lat_total;
   assign rsp_chan.total_occupancy = rsp_data_ff.occ_total;
   assign rsp_chan.min_latency     = rsp_data_ff.lat_min;
   assign rsp_chan.max_latency     = rsp_data_ff.lat_max;
   assign rsp_chan.min_occupancy   = rsp_data_ff.occ_min;
   assign rsp_chan.max_occupancy   = rsp_data_ff.occ_max;

   `NRLS_ASSERT_NOW(a_sp_range, clock, reset, 1'b1, sp_ff <= SP_W'(STACK_DEPTH))
   `NRLS_ASSERT_NEXT(a_accept_to_calc, clock, reset, req_fire, state_ff == ST_CALC)
   `NRLS_ASSERT_NEXT(a_commit_hold, clock, reset, (state_ff == ST_COMMIT) && !can_go, (state_ff == ST_COMMIT) && $stable(sp_ff))
   `NRLS_ASSERT_NEXT(a_result_out, clock, reset, (state_ff == ST_COMMIT) && can_go && produce, rsp_valid_ff)

endmodule

`default_nettype wire
